[sv/char_lcd_nibble_sequencer_unit_defines.svh]
// assertion macros of the lcd nibble sequencer, used by the controller
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define CLNS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("clns assertion failed");
// condition must never be seen outside reset
`define CLNS_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("clns forbidden condition seen");
`else
`define CLNS_ASSERT(label, prop)
`define CLNS_NEVER(label, cond)
`endif

`endif

[sv/clns_pkg.sv]
// shared types, codes and constant tables of the lcd nibble sequencer
package clns_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_CHAR = 2'd2,
    KIND_POS  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER  = 3'd3;

  // register reset values
  localparam logic [9:0]  PULSE_RST  = 10'd10;
  localparam logic [15:0] STROBE_RST = 16'd1000;
  localparam logic [15:0] SETTLE_RST = 16'd2000;
  localparam logic [15:0] POWER_RST  = 16'd40000;

  // sequence lengths and fixed holds
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_INIT_STEP = 5'd28;
  localparam logic [STEP_W-1:0] LAST_BYTE_STEP = 5'd3;
  localparam logic [STEP_W-1:0] FIRST_CMD_STEP = 5'd9;
  localparam logic [STEP_W-1:0] FIRST_INIT_TWO = 5'd7;
  localparam logic [15:0] HOLD_FIRST_GAP = 16'd4500;
  localparam logic [15:0] HOLD_GAP       = 16'd150;
  localparam logic [15:0] HOLD_POS       = 16'd1000;
  localparam logic [3:0]  NIB_WAKE       = 4'h3;
  localparam logic [3:0]  NIB_FOUR_BIT   = 4'h2;
  localparam logic [7:0]  CMD_SET_ADDR   = 8'h80;

  // controller to datapath commands
  typedef struct packed {
    logic              capture;
    logic              load;
    logic [STEP_W-1:0] step;
  } clns_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic final_step;
  } clns_stat_t;

  // command bytes of the power-up sequence
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h08;
      3'd2:    c = 8'h01;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h0C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // display ram base address of each row
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

[sv/clns_ctrl.sv]
// controller: accepts a request and steps through its pin states
`include "char_lcd_nibble_sequencer_unit_defines.svh"
module clns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  clns_pkg::clns_stat_t stat,
  output clns_pkg::clns_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                       state, state_next;
  logic [clns_pkg::STEP_W-1:0]  step, step_next;

  // command decode
  always_comb begin
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.load    = (state == ST_RUN) && stat.out_free;
    cmd.step    = step;
  end

  assign in_stall = (state != ST_IDLE);

  // next state and step
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (stat.out_free) begin
          step_next = step + 1'b1;
          if (stat.final_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // checks
  `CLNS_ASSERT(a_capture_starts, cmd.capture |=> (state == ST_RUN) && (step == '0))
  `CLNS_ASSERT(a_final_ends, (cmd.load && stat.final_step) |=> (state == ST_IDLE))
  `CLNS_NEVER(a_no_load_idle, (state == ST_IDLE) && cmd.load)
  `CLNS_NEVER(a_step_range, (state == ST_RUN) && (step > clns_pkg::LAST_INIT_STEP))

endmodule

[sv/clns_datapath.sv]
// datapath: config registers, request capture, pin state build and output word
module clns_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [clns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      value,
  input  logic [5:0]                      column,
  input  logic [1:0]                      row,
  input  clns_pkg::clns_cmd_t              cmd,
  output clns_pkg::clns_stat_t             stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            register_select,
  output logic                            enable,
  output logic [3:0]                      nibble,
  output logic [15:0]                     hold_us,
  output logic                            last
);

  logic [9:0]       pulse_us;
  logic [15:0]      strobe_us, settle_us, power_wait_us;
  clns_pkg::kind_t  kind_q;
  logic [7:0]       byte_q;
  logic [7:0]       pos_sum;
  logic [15:0]      pulse_ext;
  logic [4:0]       offs;
  logic [7:0]       icmd;
  logic [7:0]       cur_byte;
  logic [1:0]       phase;
  logic             r_en;
  logic [3:0]       r_nib;
  logic [15:0]      r_hold;
  logic             r_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_us      <= clns_pkg::PULSE_RST;
      strobe_us     <= clns_pkg::STROBE_RST;
      settle_us     <= clns_pkg::SETTLE_RST;
      power_wait_us <= clns_pkg::POWER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clns_pkg::CFG_PULSE:  pulse_us      <= cfg_data[9:0];
        clns_pkg::CFG_STROBE: strobe_us     <= cfg_data;
        clns_pkg::CFG_SETTLE: settle_us     <= cfg_data;
        clns_pkg::CFG_POWER:  power_wait_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture, cursor address formed here
  assign pos_sum = clns_pkg::row_base(row) + {2'b00, column};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= clns_pkg::kind_t'(kind);
      if (clns_pkg::kind_t'(kind) == clns_pkg::KIND_POS) begin
        byte_q <= clns_pkg::CMD_SET_ADDR | {1'b0, pos_sum[6:0]};
      end else begin
        byte_q <= value;
      end
    end
  end

  // pin state for the current step
  assign pulse_ext = {6'd0, pulse_us};
  assign offs      = cmd.step - clns_pkg::FIRST_CMD_STEP;
  assign icmd      = clns_pkg::init_cmd(offs[4:2]);
  assign cur_byte  = (kind_q == clns_pkg::KIND_INIT) ? icmd : byte_q;
  assign phase     = (kind_q == clns_pkg::KIND_INIT) ? offs[1:0] : cmd.step[1:0];

  always_comb begin
    r_en   = ~phase[0];
    r_nib  = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
    r_hold = pulse_ext;
    r_last = (cmd.step == clns_pkg::LAST_BYTE_STEP);
    unique case (kind_q)
      clns_pkg::KIND_INIT: begin
        r_last = (cmd.step == clns_pkg::LAST_INIT_STEP);
        priority if (cmd.step == '0) begin
          r_en   = 1'b0;
          r_nib  = 4'h0;
          r_hold = power_wait_us;
        end else if (cmd.step < clns_pkg::FIRST_CMD_STEP) begin
          // wake-up nibbles, strobe on odd steps
          r_en  = cmd.step[0];
          r_nib = (cmd.step >= clns_pkg::FIRST_INIT_TWO) ? clns_pkg::NIB_FOUR_BIT
                                                         : clns_pkg::NIB_WAKE;
          if (cmd.step[0]) begin
            r_hold = pulse_ext;
          end else if (cmd.step == 5'd2) begin
            r_hold = clns_pkg::HOLD_FIRST_GAP;
          end else begin
            r_hold = clns_pkg::HOLD_GAP;
          end
        end else begin
          r_hold = (phase == 2'd3) ? 16'd0 : pulse_ext;
        end
      end
      clns_pkg::KIND_CMD: begin
        r_hold = (phase == 2'd3) ? settle_us : pulse_ext;
      end
      clns_pkg::KIND_CHAR: begin
        unique case (phase)
          2'd1:    r_hold = 16'd0;
          2'd3:    r_hold = settle_us;
          default: r_hold = strobe_us;
        endcase
      end
      clns_pkg::KIND_POS: begin
        r_hold = (phase == 2'd3) ? clns_pkg::HOLD_POS : pulse_ext;
      end
      default: ;
    endcase
  end

  // status back to the controller
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.final_step = r_last;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      register_select <= (kind_q == clns_pkg::KIND_CHAR);
      enable          <= r_en;
      nibble          <= r_nib;
      hold_us         <= r_hold;
      last            <= r_last;
    end
  end

endmodule

[sv/char_lcd_nibble_sequencer_unit.sv]
// top level of the character lcd 4-bit nibble sequencer
//
//  channel | handshake          | words
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | kind, value, column, row
//  out     | out_valid/out_stall| register_select, enable, nibble, hold_us, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a request is captured, then the step counter in the controller paces out
// its pin state words one per cycle while the output register is free:
// four words for kinds 1 to 3, twenty-nine words for initialise.
// output stalls hold the step counter; the next request is taken as soon
// as the final word of the previous one sits in the output register.
// synchronous reset restores the timing registers; cfg_ready is always high.
module char_lcd_nibble_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     value,
  input  logic [5:0]                     column,
  input  logic [1:0]                     row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           register_select,
  output logic                           enable,
  output logic [3:0]                     nibble,
  output logic [15:0]                    hold_us,
  output logic                           last
);

  clns_pkg::clns_cmd_t  cmd;
  clns_pkg::clns_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencing control
  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers and pin state datapath
  clns_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .value           (value),
    .column          (column),
    .row             (row),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .register_select (register_select),
    .enable          (enable),
    .nibble          (nibble),
    .hold_us         (hold_us),
    .last            (last)
  );

endmodule

[tb/lcd_pin_checker.sv]
// checker that predicts and compares the pin state words of the lcd nibble sequencer
module lcd_pin_checker
  import clns_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [7:0]           value,
  input  logic [5:0]           column,
  input  logic [1:0]           row,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 register_select,
  input  logic                 enable,
  input  logic [3:0]           nibble,
  input  logic [15:0]          hold_us,
  input  logic                 last,
  output int unsigned          faults,
  output int unsigned          pending
);

  // one expected pin state
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        fin;
  } pin_word_t;

  pin_word_t   pin_q[$];
  logic [9:0]  pulse_t;
  logic [15:0] strobe_t;
  logic [15:0] settle_t;
  logic [15:0] power_t;

  initial begin
    faults  = 0;
    pending = 0;
  end

  // print one line for each fault and count it
  task automatic report_fault(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    faults++;
  endtask

  task automatic push_pin(input logic rs, input logic en, input logic [3:0] nib,
                          input logic [15:0] hold, input logic fin);
    pin_word_t w;
    w.rs   = rs;
    w.en   = en;
    w.nib  = nib;
    w.hold = hold;
    w.fin  = fin;
    pin_q.push_back(w);
  endtask

  // a byte goes out as two strobes, high nibble first
  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [15:0] hi_t,
                           input logic [15:0] lo_t, input logic [15:0] fin_t,
                           input logic fin);
    push_pin(rs, 1'b1, b[7:4], hi_t, 1'b0);
    push_pin(rs, 1'b0, b[7:4], lo_t, 1'b0);
    push_pin(rs, 1'b1, b[3:0], hi_t, 1'b0);
    push_pin(rs, 1'b0, b[3:0], fin_t, fin);
  endtask

  // expected pin states of one request under the current timing registers
  task automatic predict_request(input kind_t k, input logic [7:0] v,
                                 input logic [5:0] col, input logic [1:0] r);
    logic [15:0] pulse16;
    logic [7:0]  cmd;
    logic [7:0]  base;
    int          i;
    pulse16 = {6'd0, pulse_t};
    case (k)
      KIND_INIT: begin
        // power wait, then the wake-up nibbles and the setup commands
        push_pin(1'b0, 1'b0, 4'd0, power_t, 1'b0);
        for (i = 0; i < 4; i++) begin
          push_pin(1'b0, 1'b1, (i == 3) ? NIB_FOUR_BIT : NIB_WAKE, pulse16, 1'b0);
          push_pin(1'b0, 1'b0, (i == 3) ? NIB_FOUR_BIT : NIB_WAKE,
                   (i == 0) ? HOLD_FIRST_GAP : HOLD_GAP, 1'b0);
        end
        for (i = 0; i < 5; i++) begin
          case (i)
            0: cmd = 8'h28;
            1: cmd = 8'h08;
            2: cmd = 8'h01;
            3: cmd = 8'h06;
            default: cmd = 8'h0C;
          endcase
          push_byte(1'b0, cmd, pulse16, pulse16, 16'd0, i == 4);
        end
      end
      KIND_CMD: begin
        push_byte(1'b0, v, pulse16, pulse16, settle_t, 1'b1);
      end
      KIND_CHAR: begin
        push_byte(1'b1, v, strobe_t, 16'd0, settle_t, 1'b1);
      end
      default: begin
        // cursor address wraps within seven bits
        case (r)
          2'd0: base = 8'h00;
          2'd1: base = 8'h40;
          2'd2: base = 8'h14;
          default: base = 8'h54;
        endcase
        cmd = ((base + {2'b00, col}) & 8'h7F) | CMD_SET_ADDR;
        push_byte(1'b0, cmd, pulse16, pulse16, HOLD_POS, 1'b1);
      end
    endcase
  endtask

  // watch the three channels
  always @(posedge clk) begin : watch
    pin_word_t want;
    if (rst) begin
      pin_q.delete();
      pulse_t  = PULSE_RST;
      strobe_t = STROBE_RST;
      settle_t = SETTLE_RST;
      power_t  = POWER_RST;
      pending <= 0;
    end else begin
      // register writes, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PULSE:  pulse_t  = cfg_data[9:0];
          CFG_STROBE: strobe_t = cfg_data;
          CFG_SETTLE: settle_t = cfg_data;
          CFG_POWER:  power_t  = cfg_data;
          default: ;
        endcase
      end
      // compare each accepted word with the oldest expectation
      if (out_valid && !out_stall) begin
        if (pin_q.size() == 0) begin
          report_fault($sformatf(
            "word with nothing expected: rs %0b e %0b nib %h hold %0d last %0b",
            register_select, enable, nibble, hold_us, last));
        end else begin
          want = pin_q.pop_front();
          if (register_select !== want.rs)
            report_fault($sformatf("register_select %0b, expected %0b",
                                   register_select, want.rs));
          if (enable !== want.en)
            report_fault($sformatf("enable %0b, expected %0b", enable, want.en));
          if (nibble !== want.nib)
            report_fault($sformatf("nibble %h, expected %h", nibble, want.nib));
          if (hold_us !== want.hold)
            report_fault($sformatf("hold_us %0d, expected %0d", hold_us, want.hold));
          if (last !== want.fin)
            report_fault($sformatf("last %0b, expected %0b", last, want.fin));
        end
      end
      // predict the words of each accepted request
      if (in_valid && !in_stall) predict_request(kind_t'(kind), value, column, row);
      pending <= pin_q.size();
    end
  end

endmodule

[tb/testbench.sv]
// top of the lcd nibble sequencer bench: clock, reset, stimulus and verdict
module testbench;
  import clns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           kind = '0;
  logic [7:0]           value = '0;
  logic [5:0]           column = '0;
  logic [1:0]           row = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 register_select;
  logic                 enable;
  logic [3:0]           nibble;
  logic [15:0]          hold_us;
  logic                 last;

  logic                 calm = 1'b0;
  logic                 long_hold = 1'b0;
  int unsigned          faults;
  int unsigned          pending;
  int unsigned          sent = 0;
  int unsigned          cycles = 0;
  int unsigned          tx_quiet = 0;
  int unsigned          stall_left = 0;
  int unsigned          quiet_left = 0;
  logic [CFG_IDX_W-1:0] wr_idx_q[$];
  logic [15:0]          wr_dat_q[$];

  char_lcd_nibble_sequencer_unit dut (.*);
  lcd_pin_checker                chk (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, quiet stretches and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      out_stall <= 1'b0;
      quiet_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          stall_left = $urandom_range(1, 10) - 1;
          out_stall <= 1'b1;
        end
        2: begin
          quiet_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // long hold-off so that the block fills up and stalls its input
  initial begin
    wait (sent >= 120);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  // offer one request, with an occasional idle burst first
  task automatic send_item(input kind_t k, input logic [7:0] v, input logic [5:0] col,
                           input logic [1:0] r);
    if (!calm) begin
      if (tx_quiet > 0) begin
        tx_quiet--;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
          end
          2: tx_quiet = $urandom_range(5, 15);
          default: ;
        endcase
      end
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    column   <= col;
    row      <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // mostly bytes and positions, now and then a full initialisation
  task automatic send_random();
    kind_t      k;
    logic [5:0] col;
    k   = ($urandom_range(0, 24) == 0) ? KIND_INIT : kind_t'($urandom_range(1, 3));
    col = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(40, 63))
                                      : 6'($urandom_range(0, 39));
    send_item(k, 8'($urandom), col, 2'($urandom));
  endtask

  // stop offering and wait until every expected word has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    wr_idx_q.push_back(idx);
    wr_dat_q.push_back(d);
  endtask

  // write the queued registers back to back
  task automatic write_regs();
    while (wr_idx_q.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= wr_idx_q.pop_front();
      cfg_data  <= wr_dat_q.pop_front();
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests under reset timing
    send_item(KIND_INIT, 8'hFF, 6'h3F, 2'd3);
    send_item(KIND_CMD, 8'h00, 6'd0, 2'd0);
    send_item(KIND_CMD, 8'hFF, 6'd0, 2'd0);
    send_item(KIND_CHAR, 8'h00, 6'd0, 2'd0);
    send_item(KIND_CHAR, 8'hFF, 6'd0, 2'd0);
    send_item(KIND_CHAR, 8'hA5, 6'd0, 2'd0);
    send_item(KIND_CMD, 8'h5A, 6'd0, 2'd0);
    send_item(KIND_POS, 8'h00, 6'd0, 2'd0);
    send_item(KIND_POS, 8'h00, 6'd39, 2'd1);
    send_item(KIND_POS, 8'h00, 6'd0, 2'd2);
    send_item(KIND_POS, 8'h00, 6'd39, 2'd3);
    // columns past the row wrap the address
    send_item(KIND_POS, 8'h00, 6'd63, 2'd3);
    send_item(KIND_POS, 8'hFF, 6'd63, 2'd1);
    send_item(KIND_INIT, 8'h00, 6'd0, 2'd0);

    // shortest timings
    drain();
    queue_reg(CFG_PULSE, 16'd1);
    queue_reg(CFG_STROBE, 16'd1);
    queue_reg(CFG_SETTLE, 16'd0);
    queue_reg(CFG_POWER, 16'd0);
    write_regs();
    send_item(KIND_INIT, 8'h00, 6'd0, 2'd0);
    send_item(KIND_CMD, 8'h81, 6'd0, 2'd0);
    send_item(KIND_CHAR, 8'h7E, 6'd0, 2'd0);
    send_item(KIND_POS, 8'h00, 6'd5, 2'd2);
    repeat (55) send_random();

    // longest timings
    drain();
    queue_reg(CFG_PULSE, 16'd1000);
    queue_reg(CFG_STROBE, 16'hFFFF);
    queue_reg(CFG_SETTLE, 16'hFFFF);
    queue_reg(CFG_POWER, 16'hFFFF);
    write_regs();
    send_item(KIND_INIT, 8'h00, 6'd0, 2'd0);
    send_item(KIND_CHAR, 8'hC3, 6'd0, 2'd0);
    repeat (60) send_random();

    // zero pulse and strobe, writes to unused indexes
    drain();
    queue_reg(CFG_PULSE, 16'd0);
    queue_reg(CFG_STROBE, 16'd0);
    queue_reg(CFG_SETTLE, 16'd1);
    queue_reg(CFG_POWER, 16'd1);
    queue_reg(CFG_IDX_W'(5), 16'hFFFF);
    queue_reg(CFG_IDX_W'(6), 16'h0000);
    write_regs();
    repeat (60) send_random();

    // pulse wider than its register, random others
    drain();
    queue_reg(CFG_PULSE, 16'hFFFF);
    queue_reg(CFG_IDX_W'(4), 16'h1234);
    queue_reg(CFG_STROBE, 16'($urandom));
    queue_reg(CFG_SETTLE, 16'($urandom));
    queue_reg(CFG_POWER, 16'($urandom));
    queue_reg(CFG_IDX_W'(7), 16'hFFFF);
    write_regs();
    repeat (60) send_random();

    // random timings within range
    drain();
    queue_reg(CFG_PULSE, 16'($urandom_range(1, 1000)));
    queue_reg(CFG_STROBE, 16'($urandom_range(1, 65535)));
    queue_reg(CFG_SETTLE, 16'($urandom));
    queue_reg(CFG_POWER, 16'($urandom));
    write_regs();
    repeat (60) send_random();

    // back to reset timing, no idling on either side
    drain();
    calm <= 1'b1;
    queue_reg(CFG_PULSE, {6'd0, PULSE_RST});
    queue_reg(CFG_STROBE, STROBE_RST);
    queue_reg(CFG_SETTLE, SETTLE_RST);
    queue_reg(CFG_POWER, POWER_RST);
    write_regs();
    repeat (80) send_random();

    // let the last words out, then the verdict
    drain();
    repeat (40) @(posedge clk);
    if (faults == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/clns_pkg.sv
sv/clns_ctrl.sv
sv/clns_datapath.sv
sv/char_lcd_nibble_sequencer_unit.sv
tb/lcd_pin_checker.sv
tb/testbench.sv
